// File: rtl/core/bgd_pkg.sv
// Package for the button gesture detector: shared constants, register
// indexes, word types for both channels and the compare-flag struct.
// No dependencies.
`default_nettype none

package bgd_pkg;

  // Defaults for the top-level parameters.
  localparam int BGD_SLOTS_DEF     = 3;
  localparam int BGD_TICK_BITS_DEF = 32;

  // Field widths fixed by the register map and the channel words.
  localparam int WIN_W      = 31;
  localparam int CNT_W      = 8;
  localparam int USE_W      = 2;
  localparam int SLOT_OUT_W = 2;
  localparam int HOLD_W     = 32;
  localparam int EDGE_W     = 32;

  // Configuration port shape.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register indexes. Slot s uses REG_WINDOW_0 + REG_STRIDE*s and
  // REG_COUNT_0 + REG_STRIDE*s.
  localparam int REG_SLOTS_IN_USE = 0;
  localparam int REG_WINDOW_0     = 1;
  localparam int REG_COUNT_0      = 2;
  localparam int REG_STRIDE       = 2;

  // Input word: one button edge.
  typedef struct packed {
    logic [EDGE_W-1:0] edge_time;
  } bgd_in_t;

  // Output word: one result per edge.
  typedef struct packed {
    logic                  level_pressed;
    logic [HOLD_W-1:0]     hold_ticks;
    logic                  gesture_fired;
    logic [SLOT_OUT_W-1:0] gesture_slot;
  } bgd_out_t;

  // Flags from the shared tick unit.
  typedef struct packed {
    logic at_most;   // difference <= window
    logic at_least;  // difference >= window
  } bgd_cmp_t;

endpackage

`default_nettype wire

// File: rtl/core/bgd_chan_if.sv
// Valid/ready channel carrying one word of a given payload type.
// Depends on nothing; the payload type comes from the instantiating side.
`default_nettype none

interface bgd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bgd_tick_unit.sv
// Shared tick arithmetic: one wrapping subtract and a compare of the
// difference against a window. Depends on bgd_pkg.
`default_nettype none

module bgd_tick_unit #(
  parameter int TICK_BITS = bgd_pkg::BGD_TICK_BITS_DEF
) (
  input  logic [TICK_BITS-1:0]      a,
  input  logic [TICK_BITS-1:0]      b,
  input  logic [bgd_pkg::WIN_W-1:0] window,
  output logic [TICK_BITS-1:0]      diff,
  output bgd_pkg::bgd_cmp_t         flags
);
  import bgd_pkg::*;

  localparam int CMP_W = (TICK_BITS > WIN_W) ? TICK_BITS : WIN_W;

  logic [CMP_W-1:0] diff_ext;
  logic [CMP_W-1:0] win_ext;

  // Difference wraps modulo 2^TICK_BITS.
  assign diff = a - b;

  // Compare at a common width so neither side is cut.
  assign diff_ext       = CMP_W'(diff);
  assign win_ext        = CMP_W'(window);
  assign flags.at_most  = (diff_ext <= win_ext);
  assign flags.at_least = (diff_ext >= win_ext);

endmodule

`default_nettype wire

// File: rtl/core/button_gesture_detector.sv
// Button gesture detector top level: sequencer, slot state and registers.
// Depends on bgd_pkg, bgd_chan_if and bgd_tick_unit.
//
// Each input word is one button edge with its tick timestamp; each edge
// yields exactly one output word. A press edge goes from acceptance
// through the DONE state into the output register. A release edge goes
// through the HOLD state, then the SCAN state, which checks at most
// min(slots_in_use, GESTURE_SLOTS) slots and, when no slot fires, makes
// one end-of-scan check, and then DONE: the release hold time and every
// slot check share one subtract/compare unit, one use per cycle. The input
// is not ready while an edge is in work; a finished word waits in the
// output register without blocking the next edge from being accepted.
// Registers may be written whenever the block is idle.
`default_nettype none

module button_gesture_detector #(
  parameter int GESTURE_SLOTS = bgd_pkg::BGD_SLOTS_DEF,
  parameter int TICK_BITS     = bgd_pkg::BGD_TICK_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  bgd_chan_if.sink                       edges,
  bgd_chan_if.source                     results,
  input  logic                           wr_en,
  input  logic [bgd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bgd_pkg::CFG_DATA_W-1:0] wr_data
);
  import bgd_pkg::*;

  localparam int SLOT_W = (GESTURE_SLOTS > 1) ? $clog2(GESTURE_SLOTS) : 1;
  localparam logic [USE_W-1:0] SLOT_LIMIT = USE_W'(GESTURE_SLOTS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HOLD = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  // Configuration registers.
  logic [USE_W-1:0] slots_in_use;
  logic [WIN_W-1:0] window_ticks [GESTURE_SLOTS];
  logic [CNT_W-1:0] press_count  [GESTURE_SLOTS];

  // Sequencer and button state.
  logic [1:0]               state;
  logic [USE_W-1:0]         slot_idx;
  logic                     is_pressed;
  logic [TICK_BITS-1:0]     press_mark;
  logic [TICK_BITS-1:0]     cur_time;

  // Per-slot window state.
  logic [TICK_BITS-1:0]     open_time [GESTURE_SLOTS];
  logic [GESTURE_SLOTS-1:0] win_valid;
  logic [CNT_W-1:0]         tally     [GESTURE_SLOTS];

  // Result being built and the output register.
  logic                     res_fired;
  logic [SLOT_OUT_W-1:0]    res_slot;
  logic [HOLD_W-1:0]        res_hold;
  logic                     out_valid;
  bgd_out_t                 out_word;

  // Scan decode and shared unit hookup.
  logic [USE_W-1:0]         lim;
  logic                     scan_live;
  logic [SLOT_W-1:0]        idx;
  logic                     click_mode;
  logic [CNT_W-1:0]         tally_inc;
  logic                     hit;
  logic [TICK_BITS-1:0]     now;
  logic [TICK_BITS-1:0]     op_a;
  logic [TICK_BITS-1:0]     op_b;
  logic [TICK_BITS-1:0]     diff;
  bgd_cmp_t                 flags;

  assign now = TICK_BITS'(edges.data.edge_time);

  // Slots past the configured count or the built count are not scanned.
  assign lim        = (slots_in_use > SLOT_LIMIT) ? SLOT_LIMIT : slots_in_use;
  assign scan_live  = (slot_idx < lim);
  assign idx        = scan_live ? slot_idx[SLOT_W-1:0] : '0;
  assign click_mode = (press_count[idx] != '0);
  assign tally_inc  = tally[idx] + CNT_W'(1);
  assign hit        = (tally_inc == press_count[idx]);

  // Operand selection for the shared unit. A click slot with no open
  // window opens one now, so its difference is zero.
  always_comb begin
    op_a = cur_time;
    op_b = press_mark;
    if (state == ST_SCAN) begin
      if (click_mode) begin
        op_a = cur_time;
        op_b = win_valid[idx] ? open_time[idx] : cur_time;
      end else begin
        op_a = press_mark;
        op_b = '0;
      end
    end
  end

  bgd_tick_unit #(
    .TICK_BITS (TICK_BITS)
  ) u_tick (
    .a      (op_a),
    .b      (op_b),
    .window (window_ticks[idx]),
    .diff   (diff),
    .flags  (flags)
  );

  // Control state, configuration and per-slot counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_idx     <= '0;
      is_pressed   <= 1'b0;
      win_valid    <= '0;
      out_valid    <= 1'b0;
      slots_in_use <= '0;
      for (int s = 0; s < GESTURE_SLOTS; s++) begin
        tally[s]        <= '0;
        window_ticks[s] <= '0;
        press_count[s]  <= '0;
      end
    end else begin
      // Register writes; unknown indexes fall through.
      if (wr_en) begin
        if (wr_index == CFG_IDX_W'(REG_SLOTS_IN_USE)) begin
          slots_in_use <= wr_data[USE_W-1:0];
        end
        for (int s = 0; s < GESTURE_SLOTS; s++) begin
          if (wr_index == CFG_IDX_W'(REG_WINDOW_0 + REG_STRIDE * s)) begin
            window_ticks[s] <= wr_data[WIN_W-1:0];
          end
          if (wr_index == CFG_IDX_W'(REG_COUNT_0 + REG_STRIDE * s)) begin
            press_count[s] <= wr_data[CNT_W-1:0];
          end
        end
      end

      // Output register: load a finished word, or free it once taken.
      if (state == ST_DONE && (!out_valid || results.ready)) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (edges.valid) begin
            is_pressed <= ~is_pressed;
            state      <= is_pressed ? ST_HOLD : ST_DONE;
          end
        end
        ST_HOLD: begin
          slot_idx <= '0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (!scan_live) begin
            state <= ST_DONE;
          end else if (click_mode) begin
            if (flags.at_most) begin
              if (hit) begin
                tally[idx]     <= '0;
                win_valid[idx] <= 1'b0;
                state          <= ST_DONE;
              end else begin
                tally[idx]     <= tally_inc;
                win_valid[idx] <= 1'b1;
                slot_idx       <= slot_idx + USE_W'(1);
              end
            end else begin
              // Release outside the window closes it without counting.
              tally[idx]     <= '0;
              win_valid[idx] <= 1'b0;
              slot_idx       <= slot_idx + USE_W'(1);
            end
          end else if (flags.at_least) begin
            state <= ST_DONE;
          end else begin
            slot_idx <= slot_idx + USE_W'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid || results.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: times, result fields and the output word.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (edges.valid) begin
          cur_time  <= now;
          res_fired <= 1'b0;
          res_slot  <= '0;
          res_hold  <= '0;
          if (!is_pressed) begin
            press_mark <= now;
          end
        end
      end
      ST_HOLD: begin
        press_mark <= diff;
        res_hold   <= HOLD_W'(diff);
      end
      ST_SCAN: begin
        if (scan_live) begin
          if (click_mode) begin
            if (flags.at_most) begin
              if (hit) begin
                res_fired <= 1'b1;
                res_slot  <= SLOT_OUT_W'(slot_idx);
              end else begin
                open_time[idx] <= op_b;
              end
            end
          end else if (flags.at_least) begin
            res_fired <= 1'b1;
            res_slot  <= SLOT_OUT_W'(slot_idx);
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || results.ready) begin
          out_word.level_pressed <= is_pressed;
          out_word.hold_ticks    <= res_hold;
          out_word.gesture_fired <= res_fired;
          out_word.gesture_slot  <= res_slot;
        end
      end
      default: begin
      end
    endcase
  end

  assign edges.ready   = (state == ST_IDLE);
  assign results.valid = out_valid;
  assign results.data  = out_word;

  // A press word never reports a gesture or a hold time.
  a_press_quiet: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.level_pressed
      |-> !results.data.gesture_fired && (results.data.hold_ticks == '0))
    else $error("press word carries a gesture or hold time");

  // Every accepted edge flips the button level.
  a_level_flips: assert property (@(posedge clk) disable iff (rst)
    edges.valid && edges.ready |=> (is_pressed != $past(is_pressed)))
    else $error("button level did not toggle on an edge");

  // A fired slot always lies within the built slot count.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.gesture_fired
      |-> (results.data.gesture_slot < SLOT_OUT_W'(GESTURE_SLOTS)))
    else $error("fired slot beyond the built slots");

  // The scan pointer never runs past the active slot count.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (slot_idx <= lim))
    else $error("scan pointer past the active slots");

  // A press edge goes straight to the output without a scan.
  a_press_path: assert property (@(posedge clk) disable iff (rst)
    edges.valid && edges.ready && !is_pressed |=> (state == ST_DONE))
    else $error("press edge entered the scan");

endmodule

`default_nettype wire
